### src/rsct_pkg.sv
// Shared types, constants and helper functions for the rectangle symbol count table.
`default_nettype none
package rsct_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DEPTH    = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int CNT_W     = 13;
    localparam int DIM_W     = 7;
    localparam int SYM_W     = 2;
    localparam int CFG_IDX_W = 1;
    localparam int STEP_W    = 3;

    localparam logic [DIM_W-1:0]  DIM_RESET = 7'd64;
    localparam logic [STEP_W-1:0] QRY_LAST  = 3'd4;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [SYM_W-1:0] SYM_J = 2'd0;
    localparam logic [SYM_W-1:0] SYM_O = 2'd1;
    localparam logic [SYM_W-1:0] SYM_I = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef struct packed {
        logic [CNT_W-1:0] j;
        logic [CNT_W-1:0] o;
        logic [CNT_W-1:0] i;
    } t_counts;

    localparam int ENTRY_W = $bits(t_counts);

    typedef struct packed {
        logic             action;
        logic [SYM_W-1:0] symbol;
        logic [DIM_W-1:0] top_row;
        logic [DIM_W-1:0] left_col;
        logic [DIM_W-1:0] bottom_row;
        logic [DIM_W-1:0] right_col;
    } t_in_word;

    typedef struct packed {
        logic [CNT_W-1:0] count_j;
        logic [CNT_W-1:0] count_o;
        logic [CNT_W-1:0] count_i;
        logic             bad_query;
    } t_out_word;

    typedef struct packed {
        logic    we;
        t_addr   waddr;
        t_counts wdata;
        t_addr   raddr;
    } t_ram_req;

    function automatic t_addr f_addr(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        return ADDR_W'(32'(row) * MAX_COLS + 32'(col));
    endfunction

    function automatic logic [DIM_W-1:0] f_clamp(input logic [DIM_W-1:0] v, input int maxv);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > maxv) begin
            res = DIM_W'(maxv);
        end
        return res;
    endfunction

    function automatic t_counts f_bump(input t_counts c, input logic [SYM_W-1:0] sym);
        t_counts res;
        res = c;
        case (sym)
            SYM_J: res.j = c.j + CNT_W'(1);
            SYM_O: res.o = c.o + CNT_W'(1);
            SYM_I: res.i = c.i + CNT_W'(1);
            default: res = c;
        endcase
        return res;
    endfunction

    function automatic t_counts f_acc(input t_counts a, input t_counts b, input logic neg);
        t_counts res;
        if (neg) begin
            res.j = a.j - b.j;
            res.o = a.o - b.o;
            res.i = a.i - b.i;
        end else begin
            res.j = a.j + b.j;
            res.o = a.o + b.o;
            res.i = a.i + b.i;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### src/rsct_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none
module rsct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/rsct_seq.sv
// Sequencer for cell loads and rectangle queries around the prefix table memory.
`default_nettype none
module rsct_seq (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_restart,
    input  wire logic [rsct_pkg::DIM_W-1:0]  i_rows,
    input  wire logic [rsct_pkg::DIM_W-1:0]  i_cols,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire rsct_pkg::t_in_word          i_in_word,
    output logic                             o_res_valid,
    input  wire logic                        i_res_ready,
    output rsct_pkg::t_out_word              o_res_word,
    output rsct_pkg::t_ram_req               o_ram_req,
    input  wire rsct_pkg::t_counts           i_ram_rdata
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LD_WR = 4'b0010,
        S_QRY   = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    logic [rsct_pkg::ROW_W-1:0]       r_load_row, n_load_row;
    logic [rsct_pkg::COL_W-1:0]       r_load_col, n_load_col;
    rsct_pkg::t_counts                r_run, n_run;
    rsct_pkg::t_counts                r_acc, n_acc;
    logic                             r_bad, n_bad;
    logic                             r_above_zero, n_above_zero;
    rsct_pkg::t_addr                  r_waddr, n_waddr;
    logic [rsct_pkg::STEP_W-1:0]      r_step, n_step;
    logic                             r_prev_zero, n_prev_zero;
    logic                             r_prev_neg, n_prev_neg;
    logic [rsct_pkg::DIM_W-1:0]       r_top, n_top;
    logic [rsct_pkg::DIM_W-1:0]       r_left, n_left;
    logic [rsct_pkg::DIM_W-1:0]       r_bot, n_bot;
    logic [rsct_pkg::DIM_W-1:0]       r_right, n_right;

    logic                             accept;
    logic                             wrap_pos;
    logic                             bad;
    logic [rsct_pkg::ROW_W-1:0]       eff_row;
    logic [rsct_pkg::COL_W-1:0]       eff_col;
    rsct_pkg::t_counts                eff_run;
    rsct_pkg::t_counts                above;
    logic [rsct_pkg::DIM_W-1:0]       c_row;
    logic [rsct_pkg::DIM_W-1:0]       c_col;
    logic                             c_neg;
    logic                             c_zero;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    assign wrap_pos = (32'(r_load_row) >= 32'(i_rows)) || (32'(r_load_col) >= 32'(i_cols));
    assign eff_row  = wrap_pos ? '0 : r_load_row;
    assign eff_col  = wrap_pos ? '0 : r_load_col;
    assign eff_run  = wrap_pos ? '0 : r_run;

    assign bad = (i_in_word.top_row == '0) || (i_in_word.left_col == '0)
              || (i_in_word.bottom_row > i_rows) || (i_in_word.right_col > i_cols)
              || (i_in_word.top_row > i_in_word.bottom_row)
              || (i_in_word.left_col > i_in_word.right_col);

    // The four corners of inclusion and exclusion, one per read step.
    always_comb begin
        c_row = r_bot;
        c_col = r_right;
        c_neg = 1'b0;
        case (r_step[1:0])
            2'd0: begin
                c_row = r_bot;
                c_col = r_right;
                c_neg = 1'b0;
            end
            2'd1: begin
                c_row = r_top - rsct_pkg::DIM_W'(1);
                c_col = r_left - rsct_pkg::DIM_W'(1);
                c_neg = 1'b0;
            end
            2'd2: begin
                c_row = r_top - rsct_pkg::DIM_W'(1);
                c_col = r_right;
                c_neg = 1'b1;
            end
            2'd3: begin
                c_row = r_bot;
                c_col = r_left - rsct_pkg::DIM_W'(1);
                c_neg = 1'b1;
            end
            default: begin
                c_row = r_bot;
                c_col = r_right;
                c_neg = 1'b0;
            end
        endcase
        c_zero = (c_row == '0) || (c_col == '0);
    end

    assign above = r_above_zero ? '0 : i_ram_rdata;

    always_comb begin
        n_state      = r_state;
        n_load_row   = r_load_row;
        n_load_col   = r_load_col;
        n_run        = r_run;
        n_acc        = r_acc;
        n_bad        = r_bad;
        n_above_zero = r_above_zero;
        n_waddr      = r_waddr;
        n_step       = r_step;
        n_prev_zero  = r_prev_zero;
        n_prev_neg   = r_prev_neg;
        n_top        = r_top;
        n_left       = r_left;
        n_bot        = r_bot;
        n_right      = r_right;
        o_res_valid  = 1'b0;

        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_waddr;
        o_ram_req.wdata = rsct_pkg::f_acc(r_run, above, 1'b0);
        o_ram_req.raddr = rsct_pkg::f_addr(eff_row - rsct_pkg::ROW_W'(1), eff_col);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_word.action == rsct_pkg::ACT_LOAD) begin
                        n_run        = rsct_pkg::f_bump(eff_run, i_in_word.symbol);
                        n_waddr      = rsct_pkg::f_addr(eff_row, eff_col);
                        n_above_zero = (eff_row == '0);
                        n_load_row   = eff_row;
                        n_load_col   = eff_col;
                        n_state      = S_LD_WR;
                    end else begin
                        n_top   = i_in_word.top_row;
                        n_left  = i_in_word.left_col;
                        n_bot   = i_in_word.bottom_row;
                        n_right = i_in_word.right_col;
                        n_acc   = '0;
                        n_bad   = bad;
                        n_step  = '0;
                        n_state = bad ? S_FIN : S_QRY;
                    end
                end
            end
            S_LD_WR: begin
                o_ram_req.we = 1'b1;
                if (32'(r_load_col) + 32'd1 >= 32'(i_cols)) begin
                    n_load_col = '0;
                    n_run      = '0;
                    if (32'(r_load_row) + 32'd1 >= 32'(i_rows)) begin
                        n_load_row = '0;
                    end else begin
                        n_load_row = r_load_row + rsct_pkg::ROW_W'(1);
                    end
                end else begin
                    n_load_col = r_load_col + rsct_pkg::COL_W'(1);
                end
                n_state = S_IDLE;
            end
            S_QRY: begin
                o_ram_req.raddr = rsct_pkg::f_addr(rsct_pkg::ROW_W'(c_row - rsct_pkg::DIM_W'(1)),
                                                   rsct_pkg::COL_W'(c_col - rsct_pkg::DIM_W'(1)));
                if ((r_step != '0) && !r_prev_zero) begin
                    n_acc = rsct_pkg::f_acc(r_acc, i_ram_rdata, r_prev_neg);
                end
                n_prev_zero = c_zero;
                n_prev_neg  = c_neg;
                n_step      = r_step + rsct_pkg::STEP_W'(1);
                if (r_step == rsct_pkg::QRY_LAST) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_restart) begin
            n_load_row = '0;
            n_load_col = '0;
            n_run      = '0;
        end
    end

    assign o_res_word.count_j   = r_acc.j;
    assign o_res_word.count_o   = r_acc.o;
    assign o_res_word.count_i   = r_acc.i;
    assign o_res_word.bad_query = r_bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_load_row <= '0;
            r_load_col <= '0;
            r_run      <= '0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_load_row <= n_load_row;
            r_load_col <= n_load_col;
            r_run      <= n_run;
            r_step     <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc        <= n_acc;
        r_bad        <= n_bad;
        r_above_zero <= n_above_zero;
        r_waddr      <= n_waddr;
        r_prev_zero  <= n_prev_zero;
        r_prev_neg   <= n_prev_neg;
        r_top        <= n_top;
        r_left       <= n_left;
        r_bot        <= n_bot;
        r_right      <= n_right;
    end

endmodule
`default_nettype wire

### src/rect_symbol_count_table.sv
// Top level: configuration registers, prefix table memory, sequencer and output register.
// A load word reads the entry above from memory, then writes; only then is a new word taken.
// A query word goes through the accepting cycle, four reads of the one read port, a step
// to add the last read and a step to pass the result on, held while the output register
// is full. A bad query skips the reads; a new word is taken once its result is passed on.
// Reset (synchronous, active low) sets both sizes to 64 and restarts loading; the table stays.
`default_nettype none
module rect_symbol_count_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire rsct_pkg::t_in_word              i_in_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output rsct_pkg::t_out_word                  o_out_word,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rsct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rsct_pkg::DIM_W-1:0]      i_cfg_data
);

    logic [rsct_pkg::DIM_W-1:0]   r_rows_raw;
    logic [rsct_pkg::DIM_W-1:0]   r_cols_raw;
    logic                         r_out_valid;
    rsct_pkg::t_out_word          r_out_word;

    logic                         cfg_write;
    logic [rsct_pkg::DIM_W-1:0]   rows;
    logic [rsct_pkg::DIM_W-1:0]   cols;
    logic                         res_valid;
    logic                         res_ready;
    rsct_pkg::t_out_word          res_word;
    rsct_pkg::t_ram_req           ram_req;
    logic [rsct_pkg::ENTRY_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    assign rows = rsct_pkg::f_clamp(r_rows_raw, rsct_pkg::MAX_ROWS);
    assign cols = rsct_pkg::f_clamp(r_cols_raw, rsct_pkg::MAX_COLS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_raw <= rsct_pkg::DIM_RESET;
            r_cols_raw <= rsct_pkg::DIM_RESET;
        end else if (cfg_write) begin
            case (i_cfg_index)
                rsct_pkg::REG_ROW_COUNT: r_rows_raw <= i_cfg_data;
                rsct_pkg::REG_COL_COUNT: r_cols_raw <= i_cfg_data;
                default: r_rows_raw <= r_rows_raw;
            endcase
        end
    end

    rsct_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (cfg_write),
        .i_rows      (rows),
        .i_cols      (cols),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_word  (res_word),
        .o_ram_req   (ram_req),
        .i_ram_rdata (rsct_pkg::t_counts'(ram_rdata))
    );

    rsct_ram #(
        .WIDTH (rsct_pkg::ENTRY_W),
        .DEPTH (rsct_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    // The output register frees the sequencer while a finished word waits to be taken.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_word <= res_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

### test/rect_symbol_count_table_test.sv
// Self-checking testbench for the rectangle symbol count table against a grid model.
module rect_symbol_count_table_test;
    import rsct_pkg::*;

    localparam logic [SYM_W-1:0] SYM_OTHER = 2'd3;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 2000;
    localparam int DIR_N         = 18;

    localparam t_out_word NO_ANSWER  = '0;
    localparam t_out_word BAD_ANSWER = '{13'd0, 13'd0, 13'd0, 1'b1};

    typedef struct packed {
        t_in_word  word;
        logic      typed;
        t_out_word answer;
    } t_dir_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    t_in_word             in_word   = '0;
    logic                 out_ready = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 cfg_ready;
    t_out_word            out_word;

    t_counts          grid_sums   [MAX_ROWS][MAX_COLS];
    bit               grid_loaded [MAX_ROWS][MAX_COLS];
    t_counts          row_sums    = '0;
    int               next_row    = 0;
    int               next_col    = 0;
    logic [DIM_W-1:0] rows_reg    = DIM_RESET;
    logic [DIM_W-1:0] cols_reg    = DIM_RESET;

    t_out_word   pending_counts [$];
    t_out_word   want_word;
    int          bad_words   = 0;
    int          idle_cycles = 0;
    int          burst_left  = 10;
    bit          valid_held  = 1'b0;
    logic [15:0] stall_bits  = '1;
    int          stall_pos   = 0;

    t_dir_row dir_rows [DIR_N] = '{
        '{'{ACT_QUERY, SYM_J, 7'd0,   7'd1,   7'd1,   7'd1  }, 1'b1, BAD_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd0,   7'd1,   7'd1  }, 1'b1, BAD_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd1,   7'd65,  7'd1  }, 1'b1, BAD_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd1,   7'd1,   7'd65 }, 1'b1, BAD_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd2,   7'd1,   7'd1,   7'd1  }, 1'b1, BAD_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd2,   7'd1,   7'd1  }, 1'b1, BAD_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd127, 7'd127, 7'd127, 7'd127}, 1'b1, BAD_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd64,  7'd64,  7'd63,  7'd63 }, 1'b1, BAD_ANSWER},
        '{'{ACT_LOAD,  SYM_J, 7'd0,   7'd0,   7'd0,   7'd0  }, 1'b0, NO_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd1,   7'd1,   7'd1  }, 1'b1,
          '{13'd1, 13'd0, 13'd0, 1'b0}},
        '{'{ACT_LOAD,  SYM_O, 7'd0,   7'd0,   7'd0,   7'd0  }, 1'b0, NO_ANSWER},
        '{'{ACT_LOAD,  SYM_I, 7'd0,   7'd0,   7'd0,   7'd0  }, 1'b0, NO_ANSWER},
        '{'{ACT_LOAD,  SYM_OTHER, 7'd0, 7'd0, 7'd0,   7'd0  }, 1'b0, NO_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd1,   7'd1,   7'd4  }, 1'b1,
          '{13'd1, 13'd1, 13'd1, 1'b0}},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd4,   7'd1,   7'd4  }, 1'b1,
          '{13'd0, 13'd0, 13'd0, 1'b0}},
        '{'{ACT_LOAD,  SYM_I, 7'd0,   7'd0,   7'd0,   7'd0  }, 1'b0, NO_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd2,   7'd1,   7'd3  }, 1'b0, NO_ANSWER},
        '{'{ACT_QUERY, SYM_J, 7'd1,   7'd3,   7'd1,   7'd5  }, 1'b0, NO_ANSWER}
    };

    rect_symbol_count_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int dim_in_use(input logic [DIM_W-1:0] v, input int lim);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > lim) begin
            return lim;
        end
        return int'(v);
    endfunction

    function automatic t_counts sum_at(input int r, input int c);
        if (r <= 0 || c <= 0) begin
            return '0;
        end
        return grid_sums[r-1][c-1];
    endfunction

    function automatic bit readable(input int r, input int c);
        if (r <= 0 || c <= 0) begin
            return 1'b1;
        end
        return grid_loaded[r-1][c-1];
    endfunction

    function automatic void restart_loading();
        next_row = 0;
        next_col = 0;
        row_sums = '0;
    endfunction

    function automatic bit query_is_bad(input t_in_word w);
        int rows;
        int cols;
        rows = dim_in_use(rows_reg, MAX_ROWS);
        cols = dim_in_use(cols_reg, MAX_COLS);
        return w.top_row < 1 || w.left_col < 1 || int'(w.bottom_row) > rows
            || int'(w.right_col) > cols || w.top_row > w.bottom_row
            || w.left_col > w.right_col;
    endfunction

    // A good query may only touch entries that have been loaded at some point since reset.
    function automatic bit query_is_safe(input t_in_word w);
        int a;
        int b;
        int c;
        int d;
        a = int'(w.top_row);
        b = int'(w.left_col);
        c = int'(w.bottom_row);
        d = int'(w.right_col);
        return !query_is_bad(w) && readable(c, d) && readable(a - 1, b - 1)
            && readable(a - 1, d) && readable(c, b - 1);
    endfunction

    function automatic void advance_grid_model(input t_in_word w, output bit gives,
                                               output t_out_word res);
        int      rows;
        int      cols;
        t_counts above;
        t_counts br;
        t_counts tl;
        t_counts tr;
        t_counts bl;
        rows  = dim_in_use(rows_reg, MAX_ROWS);
        cols  = dim_in_use(cols_reg, MAX_COLS);
        res   = '0;
        gives = 1'b0;
        if (w.action == ACT_LOAD) begin
            if (next_row >= rows || next_col >= cols) begin
                restart_loading();
            end
            case (w.symbol)
                SYM_J: row_sums.j = row_sums.j + 13'd1;
                SYM_O: row_sums.o = row_sums.o + 13'd1;
                SYM_I: row_sums.i = row_sums.i + 13'd1;
                default: ;
            endcase
            above = sum_at(next_row, next_col + 1);
            grid_sums[next_row][next_col].j = row_sums.j + above.j;
            grid_sums[next_row][next_col].o = row_sums.o + above.o;
            grid_sums[next_row][next_col].i = row_sums.i + above.i;
            grid_loaded[next_row][next_col] = 1'b1;
            next_col++;
            if (next_col >= cols) begin
                next_col = 0;
                row_sums = '0;
                next_row++;
                if (next_row >= rows) begin
                    next_row = 0;
                end
            end
        end else begin
            gives = 1'b1;
            if (query_is_bad(w)) begin
                res.bad_query = 1'b1;
            end else begin
                br = sum_at(int'(w.bottom_row), int'(w.right_col));
                tl = sum_at(int'(w.top_row) - 1, int'(w.left_col) - 1);
                tr = sum_at(int'(w.top_row) - 1, int'(w.right_col));
                bl = sum_at(int'(w.bottom_row), int'(w.left_col) - 1);
                res.count_j = br.j + tl.j - tr.j - bl.j;
                res.count_o = br.o + tl.o - tr.o - bl.o;
                res.count_i = br.i + tl.i - tr.i - bl.i;
            end
        end
    endfunction

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word answer);
        bit        gives;
        t_out_word predicted;
        in_valid  <= 1'b1;
        in_word   <= w;
        valid_held = 1'b1;
        do @(posedge clk); while (!in_ready);
        advance_grid_model(w, gives, predicted);
        if (gives) begin
            pending_counts.push_back(typed ? answer : predicted);
        end
        burst_left--;
        if (burst_left <= 0) begin
            in_valid  <= 1'b0;
            valid_held = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // A load gives no result word, so the block may still be busy when the queue empties.
    task automatic quiesce();
        if (valid_held) begin
            in_valid  <= 1'b0;
            valid_held = 1'b0;
        end
        while (pending_counts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] rows_raw, input logic [DIM_W-1:0] cols_raw,
                             input int n_items);
        int                   k;
        int                   t;
        int                   pick;
        int                   rows;
        int                   cols;
        int                   hi;
        int                   a;
        int                   b;
        logic [31:0]          raw;
        t_in_word             w;
        logic [CFG_IDX_W-1:0] idx [2];
        logic [DIM_W-1:0]     val [2];
        bit                   swap;
        bit                   found;
        quiesce();
        swap   = 1'($urandom_range(0, 1));
        idx[0] = swap ? REG_COL_COUNT : REG_ROW_COUNT;
        val[0] = swap ? cols_raw : rows_raw;
        idx[1] = swap ? REG_ROW_COUNT : REG_COL_COUNT;
        val[1] = swap ? rows_raw : cols_raw;
        cfg_valid <= 1'b1;
        for (k = 0; k < 2; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge clk); while (!cfg_ready);
            if (idx[k] == REG_ROW_COUNT) begin
                rows_reg = val[k];
            end else begin
                cols_reg = val[k];
            end
            restart_loading();
        end
        cfg_valid <= 1'b0;
        rows = dim_in_use(rows_reg, MAX_ROWS);
        cols = dim_in_use(cols_reg, MAX_COLS);
        for (k = 0; k < n_items; k++) begin
            raw  = $urandom;
            w    = raw[$bits(t_in_word)-1:0];
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                w.action = ACT_LOAD;
            end else begin
                w.action = ACT_QUERY;
                found    = 1'b0;
                if (pick < 90) begin
                    for (t = 0; t < 32 && !found; t++) begin
                        hi = (next_row > 0 && $urandom_range(0, 1) == 1) ? next_row : rows;
                        a  = $urandom_range(1, hi);
                        b  = $urandom_range(1, cols);
                        w.top_row    = DIM_W'(a);
                        w.bottom_row = DIM_W'($urandom_range(a, hi));
                        w.left_col   = DIM_W'(b);
                        w.right_col  = DIM_W'($urandom_range(b, cols));
                        found        = query_is_safe(w);
                    end
                end
                while (!found) begin
                    raw          = $urandom;
                    w.top_row    = raw[6:0];
                    w.left_col   = raw[13:7];
                    w.bottom_row = raw[20:14];
                    w.right_col  = raw[27:21];
                    found        = query_is_bad(w) || query_is_safe(w);
                end
            end
            send_word(w, 1'b0, NO_ANSWER);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_counts.size() == 0) begin
                bad_words++;
                if (bad_words <= 10) begin
                    $display("Unexpected result word: j=%0d o=%0d i=%0d bad=%0b",
                             out_word.count_j, out_word.count_o, out_word.count_i,
                             out_word.bad_query);
                end
            end else begin
                want_word = pending_counts.pop_front();
                if (want_word.count_j !== out_word.count_j
                        || want_word.count_o !== out_word.count_o
                        || want_word.count_i !== out_word.count_i
                        || want_word.bad_query !== out_word.bad_query) begin
                    bad_words++;
                    if (bad_words <= 10) begin
                        $display("Count mismatch: expected j=%0d o=%0d i=%0d bad=%0b,",
                                 want_word.count_j, want_word.count_o, want_word.count_i,
                                 want_word.bad_query,
                                 " got j=%0d o=%0d i=%0d bad=%0b",
                                 out_word.count_j, out_word.count_o,
                                 out_word.count_i, out_word.bad_query);
                    end
                end
            end
        end
        if (stall_pos == 0) begin
            case ($urandom_range(0, 3))
                0: stall_bits = '1;
                1: stall_bits = 16'($urandom);
                2: stall_bits = 16'h0F0F;
                default: stall_bits = 16'($urandom & $urandom);
            endcase
        end
        out_ready <= stall_bits[stall_pos];
        stall_pos  = (stall_pos + 1) % 16;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL rect_symbol_count_table");
                $finish;
            end
        end
    end

    initial begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        for (k = 0; k < DIR_N; k++) begin
            send_word(dir_rows[k].word, dir_rows[k].typed, dir_rows[k].answer);
        end
        run_phase(7'd0, 7'd0, 40);
        run_phase(7'd127, 7'd1, 150);
        run_phase(7'd3, 7'd5, 200);
        run_phase(7'd1, 7'd64, 150);
        run_phase(7'd65, 7'd127, 400);
        for (k = 0; k < 5; k++) begin
            run_phase(DIM_W'($urandom_range(1, 10)), DIM_W'($urandom_range(1, 10)), 150);
        end
        run_phase(DIM_W'($urandom_range(0, 127)), DIM_W'($urandom_range(0, 127)), 100);
        quiesce();
        if (bad_words == 0) begin
            $display("PASS rect_symbol_count_table");
        end else begin
            $display("FAIL rect_symbol_count_table");
        end
        $finish;
    end

endmodule
